>>> hw/rtl/nmas_pkg.sv
// ----------------------------------------------------------------------------
// nmas_pkg
// Shared types, constants and helpers of the media autosense block.
// ----------------------------------------------------------------------------
package nmas_pkg;

    // Largest number of media leaves the table holds.
    localparam logic [3:0] MAX_LEAVES = 4'd8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_CHIP_KIND  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEDIA_LOCK = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEAF_COUNT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEAF_LOW   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEAF_HIGH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FD_MASK    = 3'd5;

    // Chip kinds.
    localparam logic [1:0] KIND_FIRST   = 2'd0;
    localparam logic [1:0] KIND_SECOND  = 2'd1;
    localparam logic [1:0] KIND_GENERIC = 2'd2;

    // Bit positions in the status word.
    localparam int ST_NET_ERR_BIT   = 1;
    localparam int ST_LINK_FAIL_BIT = 2;
    localparam int ST_NONSEL_BIT    = 8;
    localparam int ST_AUI_ACT_BIT   = 9;

    // Tick intervals in tenths of a second.
    localparam logic [9:0] T_DEFAULT = 10'd20;
    localparam logic [9:0] T_SHORT   = 10'd24;
    localparam logic [9:0] T_10S     = 10'd100;
    localparam logic [9:0] T_20S     = 10'd200;
    localparam logic [9:0] T_30S     = 10'd300;
    localparam logic [9:0] T_60S     = 10'd600;

    // Leaf types.
    localparam logic [2:0] LEAF_SIA      = 3'd0;
    localparam logic [2:0] LEAF_MII_A    = 3'd1;
    localparam logic [2:0] LEAF_MII_B    = 3'd3;
    localparam logic [2:0] LEAF_SYM      = 3'd4;

    // Media code of the type-4 leaf that steps on a network error.
    localparam logic [3:0] MEDIA_SYM_STEP = 4'd3;

    typedef struct packed {
        logic [3:0] port;
        logic       sel;
        logic       rsia;
        logic       rrx;
        logic       dup;
        logic       mtx;
        logic [9:0] tick;
        logic       nouse;
    } t_result;

    typedef struct packed {
        logic       start;
        logic [2:0] idx;
        logic [3:0] cnt;
    } t_walk_req;

    typedef struct packed {
        logic       done;
        logic       found;
        logic [2:0] idx;
        logic [3:0] port;
    } t_walk_res;

    function automatic logic [15:0] leaf_word(input logic [63:0] low,
                                              input logic [63:0] high,
                                              input logic [2:0]  idx);
        logic [63:0] w;
        w = idx[2] ? high : low;
        return w[{idx[1:0], 4'b0000} +: 16];
    endfunction

endpackage

>>> hw/rtl/nmas_walk.sv
// ----------------------------------------------------------------------------
// nmas_walk
// Leaf search unit: steps back through the leaf table one leaf per cycle and
// stops at the first leaf whose media is not full duplex or after cnt leaves.
// ----------------------------------------------------------------------------
module nmas_walk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nmas_pkg::t_walk_req i_req,
    input  logic [63:0]         i_leaf_low,
    input  logic [63:0]         i_leaf_high,
    input  logic [15:0]         i_fd_mask,
    output nmas_pkg::t_walk_res o_res
);

    logic       r_busy, n_busy;
    logic [2:0] r_idx, n_idx;
    logic [3:0] r_cnt, n_cnt;
    logic [3:0] r_k, n_k;

    logic [2:0]  w_step_idx;
    logic [15:0] w_leaf;
    logic [3:0]  w_port;
    logic        w_is_fd;
    logic [3:0]  w_k_inc;
    logic [3:0]  w_last;

    // The shared unit: one index step and one duplex-mask test.
    always_comb begin
        w_last = r_cnt - 4'd1;
        if (r_idx == 3'd0 || {1'b0, r_idx} > r_cnt) begin
            w_step_idx = w_last[2:0];
        end else begin
            w_step_idx = r_idx - 3'd1;
        end
        w_leaf  = nmas_pkg::leaf_word(i_leaf_low, i_leaf_high, w_step_idx);
        w_port  = w_leaf[3:0];
        w_is_fd = i_fd_mask[w_port];
        w_k_inc = r_k + 4'd1;
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_cnt  = r_cnt;
        n_k    = r_k;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_idx  = i_req.idx;
            n_cnt  = i_req.cnt;
            n_k    = 4'd0;
        end else if (r_busy) begin
            n_idx = w_step_idx;
            n_k   = w_k_inc;
            if (!w_is_fd || w_k_inc == r_cnt) begin
                n_busy = 1'b0;
            end
        end
    end

    always_comb begin
        o_res.done  = r_busy && (!w_is_fd || w_k_inc == r_cnt);
        o_res.found = !w_is_fd;
        o_res.idx   = w_step_idx;
        o_res.port  = w_port;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        r_k   <= n_k;
    end

endmodule

>>> hw/rtl/nic_media_autosense_core.sv
// ----------------------------------------------------------------------------
// nic_media_autosense_core
// Per-tick media selection for three chip kinds, with a leaf-table search.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Contents
//  input     in         i_in_valid/o_in_stall   i_link_status
//  output    out        o_out_valid/i_out_stall media port, action flags, tick
//  config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
//  A word runs from acceptance through the evaluate state, the search state
//  when a leaf search runs (it visits up to 8 leaves) and the finish state.
//  The search reads one leaf per cycle through a single index-step and
//  duplex-mask test unit. One word is in work at a time.
//  Reset is synchronous and active low; it restores the register defaults.
//  A stalled result waits in the output register; the next word is taken
//  meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
module nic_media_autosense_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [15:0]                       i_link_status,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [3:0]                        o_media_port,
    output logic                              o_select_media,
    output logic                              o_reset_sia,
    output logic                              o_restart_rxtx,
    output logic                              o_check_duplex,
    output logic                              o_mark_tx_start,
    output logic [9:0]                        o_next_tick_tenths,
    output logic                              o_no_usable_media,
    input  logic                              i_cfg_we,
    input  logic [nmas_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [nmas_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EVAL   = 4'b0010,
        S_WALK   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Configuration.
    logic [1:0]  r_chip_kind;
    logic        r_media_lock;
    logic [3:0]  r_leaf_count;
    logic [63:0] r_leaf_low;
    logic [63:0] r_leaf_high;
    logic [15:0] r_fd_mask;

    // Block state.
    logic [3:0] r_cur_port;
    logic       r_sense;
    logic [2:0] r_leaf_index;

    // Word in work.
    logic [15:0]       r_status;
    nmas_pkg::t_result r_pend, n_pend;
    logic              r_pend_sense, n_pend_sense;
    logic [2:0]        r_pend_idx, n_pend_idx;

    // Output register.
    logic              r_out_valid;
    nmas_pkg::t_result r_out;

    nmas_pkg::t_result   w_dec;
    logic                w_dec_sense;
    logic                w_dec_step;
    logic [3:0]          w_n;
    nmas_pkg::t_walk_req w_req;
    nmas_pkg::t_walk_res w_res;
    logic                w_accept;
    logic                w_commit;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_commit = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);
    assign w_n      = (r_leaf_count > nmas_pkg::MAX_LEAVES) ? nmas_pkg::MAX_LEAVES
                                                            : r_leaf_count;

    // Decision for the word in r_status, from the state before this tick.
    always_comb begin
        logic [15:0] lw;
        logic [3:0]  media;
        logic [2:0]  ltype;
        logic [2:0]  sbit;
        logic [7:0]  st_lo;
        logic        as_mii;
        w_dec        = '0;
        w_dec.port   = r_cur_port;
        w_dec.tick   = nmas_pkg::T_DEFAULT;
        w_dec_sense  = r_sense;
        w_dec_step   = 1'b0;
        as_mii       = 1'b0;
        lw           = nmas_pkg::leaf_word(r_leaf_low, r_leaf_high, r_leaf_index);
        media        = lw[3:0];
        ltype        = lw[6:4];
        sbit         = lw[9:7];
        st_lo        = r_status[7:0];
        if (r_chip_kind == nmas_pkg::KIND_FIRST) begin
            if (!r_media_lock && r_status[nmas_pkg::ST_NET_ERR_BIT]) begin
                w_dec.port = (r_cur_port == 4'd2) ? 4'd0 : 4'd2;
                w_dec.sel  = 1'b1;
                w_dec.mtx  = 1'b1;
            end
        end else if (r_chip_kind == nmas_pkg::KIND_SECOND) begin
            if (!r_media_lock) begin
                if (r_cur_port == 4'd0 || r_cur_port == 4'd3 || r_cur_port == 4'd4) begin
                    if (r_status[nmas_pkg::ST_LINK_FAIL_BIT]) begin
                        w_dec_sense = 1'b1;
                        w_dec.port  = r_status[nmas_pkg::ST_AUI_ACT_BIT] ? 4'd2 : 4'd1;
                        w_dec.rsia  = 1'b1;
                        w_dec.tick  = nmas_pkg::T_10S;
                    end else begin
                        w_dec.tick = nmas_pkg::T_30S;
                    end
                end else if (r_cur_port == 4'd1 || r_cur_port == 4'd2) begin
                    if (r_status[nmas_pkg::ST_NONSEL_BIT]) begin
                        w_dec.tick  = nmas_pkg::T_30S;
                        w_dec_sense = 1'b0;
                    end else if (!r_status[nmas_pkg::ST_LINK_FAIL_BIT]) begin
                        w_dec.port = 4'd0;
                        w_dec.sel  = 1'b1;
                        w_dec.tick = nmas_pkg::T_SHORT;
                    end else if (r_sense || r_status[nmas_pkg::ST_NET_ERR_BIT]) begin
                        w_dec.port = 4'd3 - r_cur_port;
                        w_dec.sel  = 1'b1;
                        w_dec.tick = nmas_pkg::T_20S;
                    end else begin
                        w_dec.tick = nmas_pkg::T_20S;
                    end
                end
            end
        end else begin
            if (w_n == 4'd0) begin
                w_dec.tick = nmas_pkg::T_60S;
            end else begin
                if (ltype == nmas_pkg::LEAF_SIA || ltype == nmas_pkg::LEAF_SYM) begin
                    if (lw[11]) begin
                        // Without media sense only the symbol-mode leaf steps on.
                        if (ltype == nmas_pkg::LEAF_SYM && media == nmas_pkg::MEDIA_SYM_STEP
                            && r_status[nmas_pkg::ST_NET_ERR_BIT]) begin
                            w_dec_step = 1'b1;
                        end
                    end else if (lw[10] != st_lo[sbit]) begin
                        as_mii = lw[12];
                    end else if (!r_media_lock) begin
                        w_dec_step = 1'b1;
                    end
                end else if (ltype == nmas_pkg::LEAF_MII_A || ltype == nmas_pkg::LEAF_MII_B) begin
                    as_mii = 1'b1;
                end
                if (as_mii) begin
                    w_dec.dup  = 1'b1;
                    w_dec.tick = nmas_pkg::T_60S;
                    w_dec_step = 1'b0;
                end
            end
        end
    end

    assign w_req.start = (r_state == S_EVAL) && w_dec_step;
    assign w_req.idx   = r_leaf_index;
    assign w_req.cnt   = w_n;

    nmas_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_leaf_low  (r_leaf_low),
        .i_leaf_high (r_leaf_high),
        .i_fd_mask   (r_fd_mask),
        .o_res       (w_res)
    );

    always_comb begin
        n_state      = r_state;
        n_pend       = r_pend;
        n_pend_sense = r_pend_sense;
        n_pend_idx   = r_pend_idx;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_pend       = w_dec;
                n_pend_sense = w_dec_sense;
                n_pend_idx   = r_leaf_index;
                n_state      = w_dec_step ? S_WALK : S_FINISH;
            end
            S_WALK: begin
                if (w_res.done) begin
                    if (w_res.found) begin
                        n_pend.port = w_res.port;
                        n_pend.sel  = 1'b1;
                        n_pend.rrx  = 1'b1;
                        n_pend.tick = nmas_pkg::T_SHORT;
                        n_pend_idx  = w_res.idx;
                    end else begin
                        n_pend.nouse = 1'b1;
                    end
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_chip_kind  <= nmas_pkg::KIND_GENERIC;
            r_media_lock <= 1'b0;
            r_leaf_count <= 4'd0;
            r_leaf_low   <= '0;
            r_leaf_high  <= '0;
            r_fd_mask    <= '0;
            r_cur_port   <= 4'd0;
            r_sense      <= 1'b0;
            r_leaf_index <= 3'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    nmas_pkg::CFG_CHIP_KIND:  r_chip_kind  <= i_cfg_data[1:0];
                    nmas_pkg::CFG_MEDIA_LOCK: r_media_lock <= i_cfg_data[0];
                    nmas_pkg::CFG_LEAF_COUNT: r_leaf_count <= i_cfg_data[3:0];
                    nmas_pkg::CFG_LEAF_LOW:   r_leaf_low   <= i_cfg_data;
                    nmas_pkg::CFG_LEAF_HIGH:  r_leaf_high  <= i_cfg_data;
                    nmas_pkg::CFG_FD_MASK:    r_fd_mask    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (w_commit) begin
                r_cur_port   <= r_pend.port;
                r_sense      <= r_pend_sense;
                r_leaf_index <= r_pend_idx;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_status <= i_link_status;
        end
        if (w_commit) begin
            r_out <= r_pend;
        end
        r_pend       <= n_pend;
        r_pend_sense <= n_pend_sense;
        r_pend_idx   <= n_pend_idx;
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_media_port       = r_out.port;
    assign o_select_media     = r_out.sel;
    assign o_reset_sia        = r_out.rsia;
    assign o_restart_rxtx     = r_out.rrx;
    assign o_check_duplex     = r_out.dup;
    assign o_mark_tx_start    = r_out.mtx;
    assign o_next_tick_tenths = r_out.tick;
    assign o_no_usable_media  = r_out.nouse;

`ifndef SYNTH
    // An accepted word is evaluated in the next cycle.
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EVAL))
        else $error("accepted word did not move to evaluation");

    // The leaf search only finishes while the sequencer waits for it.
    a_walk_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done |-> (r_state == S_WALK))
        else $error("leaf search finished outside the search state");

    // A search that found no usable leaf changes nothing.
    a_nouse_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_no_usable_media) |-> (!o_select_media && !o_restart_rxtx))
        else $error("no usable media reported together with a media switch");

    // A result is loaded only into a free or draining output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_media_port)))
        else $error("stalled result was overwritten");
`endif

endmodule

>>> tb/tb_nic_media_autosense_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nic_media_autosense_core
// Drives status words into the media autosense core and checks every result
// against a cycle-free model of the selection rules for all chip kinds. A
// short directed table covers the special cases, then random phases vary the
// configuration and the idle and stall pressure on both channels.
// ----------------------------------------------------------------------------
module tb_nic_media_autosense_core;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [nmas_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [nmas_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;

    // Port codes used by the second chip kind.
    localparam logic [3:0] PORT_TP  = 4'd0;
    localparam logic [3:0] PORT_BNC = 4'd1;
    localparam logic [3:0] PORT_AUI = 4'd2;
    localparam logic [3:0] PORT_TP3 = 4'd3;
    localparam logic [3:0] PORT_TP4 = 4'd4;

    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 56;
    localparam int DRAIN_CYCLES    = 20;

    localparam logic [1:0] PHASE_KIND [RANDOM_PHASES] = '{nmas_pkg::KIND_GENERIC,
        nmas_pkg::KIND_FIRST, nmas_pkg::KIND_SECOND, KIND_SPARE, nmas_pkg::KIND_GENERIC,
        nmas_pkg::KIND_SECOND, nmas_pkg::KIND_GENERIC, nmas_pkg::KIND_GENERIC};
    localparam logic [3:0] PHASE_COUNT [RANDOM_PHASES] = '{4'd8, 4'd1, 4'd8, 4'd15,
        4'd0, 4'd3, 4'd1, 4'd6};

    typedef struct {
        logic                             is_cfg;
        logic [nmas_pkg::CFG_INDEX_W-1:0] idx;
        logic [nmas_pkg::CFG_DATA_W-1:0]  data;
        logic [15:0]                      status;
        logic                             typed;
        nmas_pkg::t_result                want;
    } t_plan_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic [15:0]                      i_link_status = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [3:0]                       o_media_port;
    logic                             o_select_media;
    logic                             o_reset_sia;
    logic                             o_restart_rxtx;
    logic                             o_check_duplex;
    logic                             o_mark_tx_start;
    logic [9:0]                       o_next_tick_tenths;
    logic                             o_no_usable_media;
    logic                             i_cfg_we = 1'b0;
    logic [nmas_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [nmas_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    nic_media_autosense_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_link_status      (i_link_status),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_media_port       (o_media_port),
        .o_select_media     (o_select_media),
        .o_reset_sia        (o_reset_sia),
        .o_restart_rxtx     (o_restart_rxtx),
        .o_check_duplex     (o_check_duplex),
        .o_mark_tx_start    (o_mark_tx_start),
        .o_next_tick_tenths (o_next_tick_tenths),
        .o_no_usable_media  (o_no_usable_media),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the configuration registers.
    logic [1:0]  m_kind = nmas_pkg::KIND_GENERIC;
    logic        m_lock = 1'b0;
    logic [3:0]  m_count = '0;
    logic [63:0] m_leaf_low = '0;
    logic [63:0] m_leaf_high = '0;
    logic [15:0] m_fd_mask = '0;

    // Shadow of the selection state.
    logic [3:0]  m_port = '0;
    logic        m_sense_pend = 1'b0;
    logic [2:0]  m_leaf_idx = '0;

    nmas_pkg::t_result decision_q[$];
    nmas_pkg::t_result want;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned results_seen = 0;
    int unsigned settings_used = 1;
    int unsigned fd_stops = 0;
    t_plan_row   plan[$];

    function automatic logic [15:0] table_leaf(input logic [2:0] idx);
        logic [127:0] both;
        both = {m_leaf_high, m_leaf_low};
        return both[idx*16 +: 16];
    endfunction

    // Applies one tick to the shadow state and returns the decision it yields.
    function automatic nmas_pkg::t_result decide_media(input logic [15:0] st);
        nmas_pkg::t_result r;
        logic [15:0] lw;
        logic [3:0]  n;
        logic [3:0]  idx;
        logic [3:0]  media;
        logic [3:0]  port;
        logic [2:0]  ltype;
        logic        step_next;
        logic        as_mii;
        logic        found;
        int          k;
        r = '0;
        r.tick = nmas_pkg::T_DEFAULT;
        case (m_kind)
            nmas_pkg::KIND_FIRST: begin
                if (!m_lock && st[nmas_pkg::ST_NET_ERR_BIT]) begin
                    m_port = (m_port == PORT_AUI) ? PORT_TP : PORT_AUI;
                    r.sel = 1'b1;
                    r.mtx = 1'b1;
                end
            end
            nmas_pkg::KIND_SECOND: begin
                if (m_lock) begin
                    // Switching is locked out; default delay.
                end else if (m_port == PORT_TP || m_port == PORT_TP3 || m_port == PORT_TP4) begin
                    if (st[nmas_pkg::ST_LINK_FAIL_BIT]) begin
                        m_sense_pend = 1'b1;
                        m_port = st[nmas_pkg::ST_AUI_ACT_BIT] ? PORT_AUI : PORT_BNC;
                        r.rsia = 1'b1;
                        r.tick = nmas_pkg::T_10S;
                    end else begin
                        r.tick = nmas_pkg::T_30S;
                    end
                end else if (m_port == PORT_BNC || m_port == PORT_AUI) begin
                    if (st[nmas_pkg::ST_NONSEL_BIT]) begin
                        r.tick = nmas_pkg::T_30S;
                        m_sense_pend = 1'b0;
                    end else if (!st[nmas_pkg::ST_LINK_FAIL_BIT]) begin
                        m_port = PORT_TP;
                        r.sel = 1'b1;
                        r.tick = nmas_pkg::T_SHORT;
                    end else if (m_sense_pend || st[nmas_pkg::ST_NET_ERR_BIT]) begin
                        m_port = (m_port == PORT_BNC) ? PORT_AUI : PORT_BNC;
                        r.sel = 1'b1;
                        r.tick = nmas_pkg::T_20S;
                    end else begin
                        r.tick = nmas_pkg::T_20S;
                    end
                end
            end
            default: begin
                n = (m_count > nmas_pkg::MAX_LEAVES) ? nmas_pkg::MAX_LEAVES : m_count;
                if (n == 4'd0) begin
                    r.tick = nmas_pkg::T_60S;
                end else begin
                    lw = table_leaf(m_leaf_idx);
                    media = lw[3:0];
                    ltype = lw[6:4];
                    step_next = 1'b0;
                    as_mii = 1'b0;
                    if (ltype == nmas_pkg::LEAF_SIA || ltype == nmas_pkg::LEAF_SYM) begin
                        if (lw[11]) begin
                            if (ltype == nmas_pkg::LEAF_SYM && media == nmas_pkg::MEDIA_SYM_STEP
                                && st[nmas_pkg::ST_NET_ERR_BIT])
                                step_next = 1'b1;
                        end else if (lw[10] != st[lw[9:7]]) begin
                            as_mii = lw[12];
                        end else if (!m_lock) begin
                            step_next = 1'b1;
                        end
                    end else if (ltype == nmas_pkg::LEAF_MII_A
                                 || ltype == nmas_pkg::LEAF_MII_B) begin
                        as_mii = 1'b1;
                    end
                    if (as_mii) begin
                        r.dup = 1'b1;
                        r.tick = nmas_pkg::T_60S;
                    end else if (step_next) begin
                        // Walk back through the leaves, wrapping to the last one,
                        // until a half-duplex medium turns up.
                        idx = {1'b0, m_leaf_idx};
                        found = 1'b0;
                        port = '0;
                        for (k = 0; k < int'(n) && !found; k++) begin
                            idx = (idx == 4'd0 || idx > n) ? n - 4'd1 : idx - 4'd1;
                            lw = table_leaf(idx[2:0]);
                            port = lw[3:0];
                            found = !m_fd_mask[port];
                        end
                        if (found) begin
                            m_leaf_idx = idx[2:0];
                            m_port = port;
                            r.sel = 1'b1;
                            r.rrx = 1'b1;
                            r.tick = nmas_pkg::T_SHORT;
                        end else begin
                            r.nouse = 1'b1;
                        end
                    end
                end
            end
        endcase
        r.port = m_port;
        return r;
    endfunction

    function automatic nmas_pkg::t_result mk_result(input logic [3:0] port, input logic sel,
                                                    input logic rsia, input logic rrx,
                                                    input logic dup, input logic mtx,
                                                    input logic [9:0] tick,
                                                    input logic nouse);
        nmas_pkg::t_result r;
        r.port = port;
        r.sel = sel;
        r.rsia = rsia;
        r.rrx = rrx;
        r.dup = dup;
        r.mtx = mtx;
        r.tick = tick;
        r.nouse = nouse;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(input logic [nmas_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [nmas_pkg::CFG_DATA_W-1:0] data);
        t_plan_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic t_plan_row word_row(input logic [15:0] st, input logic typed,
                                           input nmas_pkg::t_result r);
        t_plan_row row;
        row = '{default: '0};
        row.status = st;
        row.typed = typed;
        row.want = r;
        return row;
    endfunction

    function automatic logic [15:0] rand_leaf();
        logic [15:0]  lw;
        int unsigned  pick;
        lw = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 60)
            lw[6:4] = $urandom_range(1) ? nmas_pkg::LEAF_SYM : nmas_pkg::LEAF_SIA;
        else if (pick < 85)
            lw[6:4] = $urandom_range(1) ? nmas_pkg::LEAF_MII_B : nmas_pkg::LEAF_MII_A;
        if ($urandom_range(99) < 75)
            lw[11] = 1'b0;
        else if (lw[6:4] == nmas_pkg::LEAF_SYM && $urandom_range(1))
            lw[3:0] = nmas_pkg::MEDIA_SYM_STEP;
        return lw;
    endfunction

    function automatic logic [63:0] rand_table();
        if ($urandom_range(9) == 0)
            return {$urandom, $urandom};
        return {rand_leaf(), rand_leaf(), rand_leaf(), rand_leaf()};
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // Lowers valid and waits until every outstanding word has its result.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (decision_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [nmas_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [nmas_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            nmas_pkg::CFG_CHIP_KIND:  m_kind = data[1:0];
            nmas_pkg::CFG_MEDIA_LOCK: m_lock = data[0];
            nmas_pkg::CFG_LEAF_COUNT: m_count = data[3:0];
            nmas_pkg::CFG_LEAF_LOW:   m_leaf_low = data;
            nmas_pkg::CFG_LEAF_HIGH:  m_leaf_high = data;
            nmas_pkg::CFG_FD_MASK:    m_fd_mask = data[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_status(input logic [15:0] st, input logic typed,
                               input nmas_pkg::t_result typed_want);
        int unsigned gap;
        nmas_pkg::t_result r;
        gap = 0;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_link_status <= st;
        do @(posedge i_clk); while (o_in_stall);
        r = decide_media(st);
        decision_q.push_back(typed ? typed_want : r);
        fd_stops += r.nouse;
        words_sent++;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= i_rst_n && stall_pct != 0 && $urandom_range(99) < stall_pct;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decision_q.size() == 0) begin
                $error("result word with nothing expected: media_port %0d, tick %0d",
                       o_media_port, o_next_tick_tenths);
                mismatches++;
            end else begin
                want = decision_q.pop_front();
                check_field("media_port", want.port, o_media_port);
                check_field("select_media", want.sel, o_select_media);
                check_field("reset_sia", want.rsia, o_reset_sia);
                check_field("restart_rxtx", want.rrx, o_restart_rxtx);
                check_field("check_duplex", want.dup, o_check_duplex);
                check_field("mark_tx_start", want.mtx, o_mark_tx_start);
                check_field("next_tick_tenths", want.tick, o_next_tick_tenths);
                check_field("no_usable_media", want.nouse, o_no_usable_media);
                results_seen++;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_nic_media_autosense_core: FAIL");
        $finish;
    end

    initial begin
        nmas_pkg::t_result idle60;
        nmas_pkg::t_result quiet;
        nmas_pkg::t_result no_pick;
        logic [15:0] st;
        int          ph;
        int          w;

        idle60 = mk_result(PORT_TP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, nmas_pkg::T_60S, 1'b0);
        quiet = mk_result(PORT_TP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, nmas_pkg::T_DEFAULT, 1'b0);
        no_pick = '0;

        // After reset: generic kind with an empty leaf table.
        plan.push_back(word_row(16'h0000, 1'b1, idle60));
        plan.push_back(word_row(16'hFFFF, 1'b1, idle60));
        plan.push_back(cfg_row(CFG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(cfg_row(CFG_SPARE_B, 64'h5A5A_A5A5_0F0F_F0F0));
        // First chip kind: upper data bits must be ignored.
        plan.push_back(cfg_row(nmas_pkg::CFG_CHIP_KIND, 64'hFFFF_FFFF_FFFF_FFFC));
        plan.push_back(word_row(16'h0002, 1'b1, mk_result(PORT_AUI, 1'b1, 1'b0, 1'b0, 1'b0,
                                                          1'b1, nmas_pkg::T_DEFAULT, 1'b0)));
        plan.push_back(word_row(16'h0002, 1'b1, mk_result(PORT_TP, 1'b1, 1'b0, 1'b0, 1'b0,
                                                          1'b1, nmas_pkg::T_DEFAULT, 1'b0)));
        plan.push_back(word_row(16'hFFFD, 1'b1, quiet));
        plan.push_back(cfg_row(nmas_pkg::CFG_MEDIA_LOCK, 64'd1));
        plan.push_back(word_row(16'hFFFF, 1'b1, quiet));
        plan.push_back(cfg_row(nmas_pkg::CFG_MEDIA_LOCK, 64'hFFFF_FFFF_FFFF_FFFE));
        // Second chip kind: walk through the three media.
        plan.push_back(cfg_row(nmas_pkg::CFG_CHIP_KIND, {62'd0, nmas_pkg::KIND_SECOND}));
        plan.push_back(word_row(16'h0004, 1'b0, no_pick));
        plan.push_back(word_row(16'h0004, 1'b0, no_pick));
        plan.push_back(word_row(16'h0100, 1'b0, no_pick));
        plan.push_back(word_row(16'h0006, 1'b0, no_pick));
        plan.push_back(word_row(16'h0000, 1'b0, no_pick));
        plan.push_back(word_row(16'h0000, 1'b0, no_pick));
        plan.push_back(word_row(16'h0204, 1'b0, no_pick));
        // Unknown kind acts as generic; an oversized count is clamped.
        plan.push_back(cfg_row(nmas_pkg::CFG_CHIP_KIND, {62'd0, KIND_SPARE}));
        plan.push_back(cfg_row(nmas_pkg::CFG_LEAF_COUNT, 64'd15));
        plan.push_back(cfg_row(nmas_pkg::CFG_LEAF_LOW, 64'h0011_0843_1489_0100));
        plan.push_back(cfg_row(nmas_pkg::CFG_LEAF_HIGH, 64'hE07F_0056_0035_0024));
        plan.push_back(cfg_row(nmas_pkg::CFG_FD_MASK, 64'h0000_0000_0000_8040));
        // The step back skips two full-duplex leaves and lands on port 5.
        plan.push_back(word_row(16'h0000, 1'b0, no_pick));
        plan.push_back(cfg_row(nmas_pkg::CFG_CHIP_KIND, {62'd0, nmas_pkg::KIND_SECOND}));
        plan.push_back(word_row(16'hFFFF, 1'b0, no_pick));
        plan.push_back(cfg_row(nmas_pkg::CFG_CHIP_KIND, {62'd0, nmas_pkg::KIND_GENERIC}));
        plan.push_back(word_row(16'h1234, 1'b0, no_pick));
        // Leaf index now lies past the count; the next step wraps to the last leaf.
        plan.push_back(cfg_row(nmas_pkg::CFG_LEAF_COUNT, 64'd2));
        plan.push_back(cfg_row(nmas_pkg::CFG_LEAF_HIGH, 64'hE07F_0056_0005_0024));
        plan.push_back(word_row(16'h0000, 1'b0, no_pick));
        plan.push_back(word_row(16'h0000, 1'b0, no_pick));
        plan.push_back(word_row(16'h0002, 1'b0, no_pick));
        plan.push_back(cfg_row(nmas_pkg::CFG_LEAF_COUNT, 64'd3));
        plan.push_back(word_row(16'h0000, 1'b0, no_pick));
        // A symbol leaf without media sense steps on a network error even when locked.
        plan.push_back(cfg_row(nmas_pkg::CFG_MEDIA_LOCK, 64'd1));
        plan.push_back(word_row(16'h0002, 1'b0, no_pick));
        // Every medium full duplex: the search gives up.
        plan.push_back(cfg_row(nmas_pkg::CFG_MEDIA_LOCK, 64'd0));
        plan.push_back(cfg_row(nmas_pkg::CFG_FD_MASK, 64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(word_row(16'h0002, 1'b0, no_pick));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_drained();
                write_reg(plan[i].idx, plan[i].data);
                settings_used++;
            end else begin
                send_status(plan[i].status, plan[i].typed, plan[i].want);
            end
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            write_reg(nmas_pkg::CFG_CHIP_KIND,
                      {$urandom, $urandom} & ~64'd3 | 64'(PHASE_KIND[ph]));
            write_reg(nmas_pkg::CFG_MEDIA_LOCK,
                      (ph == 6) ? 64'd1 : 64'($urandom_range(99) < 20));
            write_reg(nmas_pkg::CFG_LEAF_COUNT,
                      {$urandom, $urandom} & ~64'hF | 64'(PHASE_COUNT[ph]));
            write_reg(nmas_pkg::CFG_LEAF_LOW, rand_table());
            write_reg(nmas_pkg::CFG_LEAF_HIGH, rand_table());
            if (ph == 7)
                write_reg(nmas_pkg::CFG_FD_MASK, 64'hFFFF);
            else if ($urandom_range(3) == 0)
                write_reg(nmas_pkg::CFG_FD_MASK, 64'd0);
            else
                write_reg(nmas_pkg::CFG_FD_MASK, {$urandom, $urandom} & {$urandom, $urandom});
            settings_used++;
            for (w = 0; w < WORDS_PER_PHASE; w++) begin
                // Let the block empty out once with the sender held off.
                if (ph == 2 && w == WORDS_PER_PHASE / 2)
                    wait_drained();
                case ($urandom_range(19))
                    0: st = 16'h0000;
                    1: st = 16'hFFFF;
                    default: st = 16'($urandom);
                endcase
                send_status(st, 1'b0, no_pick);
            end
        end

        wait_drained();
        idle_pct = 0;
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d status words under %0d register settings, all chip kinds.",
                 words_sent, settings_used);
        $display("Checked %0d result words (%0d all-full-duplex stops), %0d mismatches.",
                 results_seen, fd_stops, mismatches);
        if (mismatches == 0 && decision_q.size() == 0)
            $display("tb_nic_media_autosense_core: PASS");
        else
            $display("tb_nic_media_autosense_core: FAIL");
        $finish;
    end

endmodule
